/* hw/rtl/assert_macros.svh */
// Assertion macros shared by the priority lock arbiter RTL.
// Needs a clock named clk in the scope of each use, and a reset named rst for PLK_ASSERT.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define PLK_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
`define PLK_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define PLK_ASSERT(label, prop, msg)
`define PLK_ASSERT_ALWAYS(label, prop, msg)
`endif
`endif

/* hw/rtl/plk_pkg.sv */
// Package of the priority lock arbiter: payload types, command and status codes.
// No dependencies.
`default_nettype none
package plk_pkg;

  localparam int ID_W              = 4;
  localparam int NUM_REQUESTERS_DEF = 8;

  localparam logic [1:0] CMD_TAKE    = 2'd0;
  localparam logic [1:0] CMD_RELEASE = 2'd1;
  localparam logic [1:0] CMD_CHANGE  = 2'd2;

  localparam logic [2:0] ST_ACQUIRED = 3'd0;
  localparam logic [2:0] ST_ALREADY  = 3'd1;
  localparam logic [2:0] ST_NOT_ACQ  = 3'd2;
  localparam logic [2:0] ST_WAITING  = 3'd3;
  localparam logic [2:0] ST_RELEASED = 3'd4;
  localparam logic [2:0] ST_ERROR    = 3'd5;

  typedef struct packed {
    logic [1:0]      cmd;
    logic [ID_W-1:0] requester_id;
    logic            will_wait;
    logic            quiet_type;
    logic            in_interrupt;
  } req_t;

  typedef struct packed {
    logic [2:0]      status;
    logic            owner_valid;
    logic [ID_W-1:0] owner_id;
    logic            reception_allowed;
    logic            grant_valid;
    logic [ID_W-1:0] grant_id;
  } rsp_t;

  // controller -> datapath
  typedef struct packed {
    logic load;  // process the accepted request and load the result register
  } ctl_t;

endpackage
`default_nettype wire

/* hw/rtl/plk_req_if.sv */
// Request channel of the priority lock arbiter: valid, ready and a plk_pkg::req_t.
// Depends on plk_pkg.
`default_nettype none
interface plk_req_if;
  logic          valid;
  logic          ready;
  plk_pkg::req_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

/* hw/rtl/plk_rsp_if.sv */
// Response channel of the priority lock arbiter: valid, ready and a plk_pkg::rsp_t.
// Depends on plk_pkg.
`default_nettype none
interface plk_rsp_if;
  logic          valid;
  logic          ready;
  plk_pkg::rsp_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

/* hw/rtl/plk_datapath.sv */
// Datapath of the priority lock arbiter: lock state, waiter bits, grant encoder
// and the result register. Depends on plk_pkg.
`default_nettype none
module plk_datapath #(
  parameter int NUM_REQUESTERS = plk_pkg::NUM_REQUESTERS_DEF
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire plk_pkg::ctl_t ctl,
  input  wire plk_pkg::req_t req,
  output plk_pkg::rsp_t      result
);

  localparam int IDX_W = $clog2(NUM_REQUESTERS);
  localparam int ID_W  = plk_pkg::ID_W;

  logic                      held, held_next;
  logic [ID_W-1:0]           holder, holder_next;
  logic [NUM_REQUESTERS-1:0] waiting_mask, waiting_mask_next;
  logic [NUM_REQUESTERS-1:0] waiting_quiet, waiting_quiet_next;
  logic                      reception_level, reception_level_next;
  plk_pkg::rsp_t             result_next;

  logic             valid_id;
  logic             is_owner;
  logic [IDX_W-1:0] idx;
  logic             wait_found;
  logic [IDX_W-1:0] wait_idx;
  logic             gv;

  // lowest waiting id wins
  always_comb begin
    wait_found = 1'b0;
    wait_idx   = '0;
    for (int i = NUM_REQUESTERS - 1; i >= 0; i--) begin
      if (waiting_mask[i]) begin
        wait_found = 1'b1;
        wait_idx   = IDX_W'(i);
      end
    end
  end

  always_comb begin
    valid_id             = req.requester_id < ID_W'(NUM_REQUESTERS);
    idx                  = req.requester_id[IDX_W-1:0];
    is_owner             = held && (holder == req.requester_id);
    held_next            = held;
    holder_next          = holder;
    waiting_mask_next    = waiting_mask;
    waiting_quiet_next   = waiting_quiet;
    reception_level_next = reception_level;
    result_next.status   = plk_pkg::ST_ERROR;
    gv                   = 1'b0;

    if (valid_id) begin
      case (req.cmd)
        plk_pkg::CMD_TAKE: begin
          if (req.in_interrupt) begin
            result_next.status = plk_pkg::ST_ERROR;
          end else if (!held) begin
            held_next            = 1'b1;
            holder_next          = req.requester_id;
            reception_level_next = !req.quiet_type;
            result_next.status   = plk_pkg::ST_ACQUIRED;
          end else if (is_owner) begin
            result_next.status = plk_pkg::ST_ALREADY;
          end else if (!req.will_wait) begin
            result_next.status = plk_pkg::ST_NOT_ACQ;
          end else if (waiting_mask[idx]) begin
            result_next.status = plk_pkg::ST_ERROR;
          end else begin
            waiting_mask_next[idx]  = 1'b1;
            waiting_quiet_next[idx] = req.quiet_type;
            result_next.status      = plk_pkg::ST_WAITING;
          end
        end
        plk_pkg::CMD_RELEASE: begin
          if (is_owner) begin
            // interrupt context still releases, but reports an error
            if (wait_found) begin
              gv                          = 1'b1;
              waiting_mask_next[wait_idx] = 1'b0;
              held_next                   = 1'b1;
              holder_next                 = ID_W'(wait_idx);
              reception_level_next        = !waiting_quiet[wait_idx];
            end else begin
              held_next            = 1'b0;
              reception_level_next = 1'b1;
            end
            result_next.status = req.in_interrupt ? plk_pkg::ST_ERROR
                                                  : plk_pkg::ST_RELEASED;
          end
        end
        plk_pkg::CMD_CHANGE: begin
          if (!req.in_interrupt && is_owner) begin
            reception_level_next = !req.quiet_type;
            result_next.status   = plk_pkg::ST_ACQUIRED;
          end
        end
        default: begin
          result_next.status = plk_pkg::ST_ERROR;
        end
      endcase
    end

    result_next.owner_valid       = held_next;
    result_next.owner_id          = held_next ? holder_next : '0;
    result_next.reception_allowed = reception_level_next;
    result_next.grant_valid       = gv;
    result_next.grant_id          = gv ? ID_W'(wait_idx) : '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held            <= 1'b0;
      holder          <= '0;
      waiting_mask    <= '0;
      waiting_quiet   <= '0;
      reception_level <= 1'b1;
    end else if (ctl.load) begin
      held            <= held_next;
      holder          <= holder_next;
      waiting_mask    <= waiting_mask_next;
      waiting_quiet   <= waiting_quiet_next;
      reception_level <= reception_level_next;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      result <= result_next;
    end
  end

endmodule
`default_nettype wire

/* hw/rtl/plk_controller.sv */
// Controller of the priority lock arbiter: tracks the result register and
// drives the handshakes. Depends on plk_pkg.
`default_nettype none
module plk_controller (
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     req_valid,
  output logic          req_ready,
  output logic          rsp_valid,
  input  wire logic     rsp_ready,
  output plk_pkg::ctl_t ctl
);

  localparam logic S_EMPTY = 1'b0;
  localparam logic S_FULL  = 1'b1;

  logic state, state_next;

  always_comb begin
    // a new transaction may enter as the held result leaves
    req_ready  = (state == S_EMPTY) || rsp_ready;
    rsp_valid  = (state == S_FULL);
    ctl.load   = req_valid && req_ready;
    state_next = state;
    case (state)
      S_EMPTY: begin
        if (ctl.load) state_next = S_FULL;
      end
      S_FULL: begin
        if (rsp_ready && !ctl.load) state_next = S_EMPTY;
      end
      default: begin
        state_next = S_EMPTY;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_EMPTY;
    end else begin
      state <= state_next;
    end
  end

endmodule
`default_nettype wire

/* hw/rtl/priority_lock_arbiter.sv */
// Priority lock arbiter: single-owner lock with a lowest-id waiter grant. Each request
// (take, release or change type) gives exactly one response in the cycle after it is
// accepted, through a result register; one transaction per cycle is sustained while the
// receiver takes each response, and a new request is taken in the cycle the pending
// response leaves. The lock state and waiting bits load with the result register.
// Depends on plk_pkg, plk_req_if, plk_rsp_if, plk_controller, plk_datapath.
`default_nettype none
`include "assert_macros.svh"
module priority_lock_arbiter #(
  parameter int NUM_REQUESTERS = plk_pkg::NUM_REQUESTERS_DEF
) (
  input wire logic  clk,
  input wire logic  rst,
  plk_req_if.sink   req,
  plk_rsp_if.source rsp
);

  plk_pkg::ctl_t ctl;
  plk_pkg::rsp_t result;

  plk_controller u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .req_ready (req.ready),
    .rsp_valid (rsp.valid),
    .rsp_ready (rsp.ready),
    .ctl       (ctl)
  );

  plk_datapath #(
    .NUM_REQUESTERS (NUM_REQUESTERS)
  ) u_dp (
    .clk    (clk),
    .rst    (rst),
    .ctl    (ctl),
    .req    (req.data),
    .result (result)
  );

  assign rsp.data = result;

  `PLK_ASSERT(a_no_overwrite,
              (req.valid && req.ready) |-> (!rsp.valid || rsp.ready),
              "result overwritten")
  `PLK_ASSERT(a_owner_range,
              (rsp.valid && rsp.data.owner_valid) |->
              (rsp.data.owner_id < plk_pkg::ID_W'(NUM_REQUESTERS)),
              "owner id out of range")
  `PLK_ASSERT(a_grant_owner,
              (rsp.valid && rsp.data.grant_valid) |->
              (rsp.data.owner_valid && rsp.data.owner_id == rsp.data.grant_id),
              "grantee is not owner")
  `PLK_ASSERT(a_free_reception,
              (rsp.valid && !rsp.data.owner_valid) |-> rsp.data.reception_allowed,
              "free lock with reception off")
  `PLK_ASSERT_ALWAYS(a_reset_empty, $past(rst) |-> !rsp.valid, "response valid after reset")

endmodule
`default_nettype wire

/* test/priority_lock_arbiter_tb.sv */
// Self-checking bench for priority_lock_arbiter: directed and random lock requests,
// responses checked in order against an in-bench prediction of the lock state.
// Depends on plk_pkg, plk_req_if, plk_rsp_if and the arbiter RTL.
`default_nettype none
module priority_lock_arbiter_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NREQ = plk_pkg::NUM_REQUESTERS_DEF;
  localparam int ID_W = plk_pkg::ID_W;
  localparam logic [1:0] CMD_UNUSED = 2'd3;
  localparam int RANDOM_ITEMS = 1800;
  localparam int IDLE_PCT = 17;
  localparam int HOLD_AT = 400;        // response count at which the receiver holds off
  localparam int HOLD_CYCLES = 80;
  localparam int CALM_FROM = 1000;     // window with no idling on either side
  localparam int CALM_TO = 1300;
  localparam int WATCHDOG_LIMIT = 1000;

  typedef struct {
    logic            held;
    logic [ID_W-1:0] holder;
    logic [NREQ-1:0] waiting;
    logic [NREQ-1:0] waiting_quiet;
    logic            reception;
  } lock_state_t;

  logic clk;
  logic rst;

  plk_req_if req_ch ();
  plk_rsp_if rsp_ch ();

  priority_lock_arbiter #(.NUM_REQUESTERS(NREQ)) dut (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch)
  );

  plk_pkg::req_t pending_reqs[$];
  plk_pkg::rsp_t expected_rsps[$];
  lock_state_t   lock_st;    // follows accepted transactions
  lock_state_t   plan_st;    // follows queued requests, steers the generator
  int            sent_count;
  int            seen_count;
  int            hold_left;
  logic          hold_done;
  int            fail_count = 0;
  int            stall_cycles;
  plk_pkg::rsp_t oldest;

  function automatic lock_state_t lock_reset();
    lock_state_t s;
    s.held = 1'b0;
    s.holder = '0;
    s.waiting = '0;
    s.waiting_quiet = '0;
    s.reception = 1'b1;
    return s;
  endfunction

  // Applies one request to the lock state and returns the response it gives.
  function automatic plk_pkg::rsp_t lock_step(inout lock_state_t s,
                                              input plk_pkg::req_t r);
    plk_pkg::rsp_t o;
    logic valid_id;
    logic is_owner;
    int   k;
    o = '0;
    o.status = plk_pkg::ST_ERROR;
    valid_id = int'(r.requester_id) < NREQ;
    is_owner = s.held && s.holder == r.requester_id;
    if (valid_id) begin
      case (r.cmd)
        plk_pkg::CMD_TAKE: begin
          if (r.in_interrupt) begin
            o.status = plk_pkg::ST_ERROR;
          end else if (!s.held) begin
            s.held = 1'b1;
            s.holder = r.requester_id;
            s.reception = !r.quiet_type;
            o.status = plk_pkg::ST_ACQUIRED;
          end else if (is_owner) begin
            o.status = plk_pkg::ST_ALREADY;
          end else if (!r.will_wait) begin
            o.status = plk_pkg::ST_NOT_ACQ;
          end else if (s.waiting[r.requester_id]) begin
            o.status = plk_pkg::ST_ERROR;
          end else begin
            s.waiting[r.requester_id] = 1'b1;
            s.waiting_quiet[r.requester_id] = r.quiet_type;
            o.status = plk_pkg::ST_WAITING;
          end
        end
        plk_pkg::CMD_RELEASE: begin
          if (is_owner) begin
            s.held = 1'b0;
            s.reception = 1'b1;
            for (k = 0; k < NREQ; k++) begin
              if (!o.grant_valid && s.waiting[k]) begin
                o.grant_valid = 1'b1;
                o.grant_id = k[ID_W-1:0];
              end
            end
            if (o.grant_valid) begin
              s.waiting[o.grant_id] = 1'b0;
              s.held = 1'b1;
              s.holder = o.grant_id;
              s.reception = !s.waiting_quiet[o.grant_id];
            end
            o.status = r.in_interrupt ? plk_pkg::ST_ERROR : plk_pkg::ST_RELEASED;
          end
        end
        plk_pkg::CMD_CHANGE: begin
          if (!r.in_interrupt && is_owner) begin
            s.reception = !r.quiet_type;
            o.status = plk_pkg::ST_ACQUIRED;
          end
        end
        default: o.status = plk_pkg::ST_ERROR;
      endcase
    end
    o.owner_valid = s.held;
    o.owner_id = s.held ? s.holder : '0;
    o.reception_allowed = s.reception;
    return o;
  endfunction

  task automatic add_req(logic [1:0] c, logic [ID_W-1:0] id, logic w, logic q, logic irq);
    plk_pkg::req_t r;
    r.cmd = c;
    r.requester_id = id;
    r.will_wait = w;
    r.quiet_type = q;
    r.in_interrupt = irq;
    pending_reqs.push_back(r);
    void'(lock_step(plan_st, r));
  endtask

  // Mostly well-formed traffic: releases and type changes come from the holder.
  task automatic add_random_req();
    int               pick;
    logic [ID_W-1:0]  id;
    logic             irq;
    pick = $urandom_range(99);
    id = ID_W'($urandom_range(NREQ - 1));
    irq = $urandom_range(99) < 10;
    if (pick < 5) begin
      add_req(2'($urandom_range(3)), ID_W'($urandom_range(15)), 1'($urandom_range(1)),
              1'($urandom_range(1)), 1'($urandom_range(1)));
    end else if (pick < 50) begin
      add_req(plk_pkg::CMD_TAKE, id, $urandom_range(99) < 80, 1'($urandom_range(1)), irq);
    end else if (pick < 85) begin
      if (plan_st.held && $urandom_range(99) < 85) id = plan_st.holder;
      add_req(plk_pkg::CMD_RELEASE, id, 1'($urandom_range(1)), 1'($urandom_range(1)), irq);
    end else begin
      if (plan_st.held && $urandom_range(99) < 80) id = plan_st.holder;
      add_req(plk_pkg::CMD_CHANGE, id, 1'($urandom_range(1)), 1'($urandom_range(1)), irq);
    end
  endtask

  task automatic wait_drained();
    while (pending_reqs.size() != 0 || req_ch.valid || expected_rsps.size() != 0)
      @(posedge clk);
  endtask

  task automatic check_field(string name, int want, int got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      fail_count++;
    end
  endtask

  always #2 clk = ~clk;

  // Request driver
  always @(posedge clk) begin
    if (rst) begin
      req_ch.valid <= 1'b0;
      req_ch.data <= '0;
      sent_count <= 0;
    end else begin
      if (req_ch.valid && req_ch.ready) begin
        expected_rsps.push_back(lock_step(lock_st, req_ch.data));
        sent_count <= sent_count + 1;
      end
      if (!req_ch.valid || req_ch.ready) begin
        if (pending_reqs.size() != 0 &&
            ((sent_count >= CALM_FROM && sent_count < CALM_TO) ||
             $urandom_range(99) >= IDLE_PCT)) begin
          req_ch.valid <= 1'b1;
          req_ch.data <= pending_reqs.pop_front();
        end else begin
          req_ch.valid <= 1'b0;
        end
      end
    end
  end

  // Response monitor
  always @(posedge clk) begin
    if (rst) begin
      rsp_ch.ready <= 1'b0;
      seen_count <= 0;
      hold_left <= 0;
      hold_done <= 1'b0;
    end else begin
      if (rsp_ch.valid && rsp_ch.ready) begin
        seen_count <= seen_count + 1;
        if (expected_rsps.size() == 0) begin
          $error("response transaction with no request outstanding");
          fail_count++;
        end else begin
          oldest = expected_rsps.pop_front();
          check_field("status", oldest.status, rsp_ch.data.status);
          check_field("owner_valid", oldest.owner_valid, rsp_ch.data.owner_valid);
          check_field("owner_id", oldest.owner_id, rsp_ch.data.owner_id);
          check_field("reception_allowed", oldest.reception_allowed,
                      rsp_ch.data.reception_allowed);
          check_field("grant_valid", oldest.grant_valid, rsp_ch.data.grant_valid);
          check_field("grant_id", oldest.grant_id, rsp_ch.data.grant_id);
        end
      end
      if (hold_left != 0) begin
        hold_left <= hold_left - 1;
        rsp_ch.ready <= 1'b0;
      end else if (!hold_done && seen_count == HOLD_AT) begin
        // long hold-off so the result register fills and the input stalls
        hold_done <= 1'b1;
        hold_left <= HOLD_CYCLES;
        rsp_ch.ready <= 1'b0;
      end else begin
        rsp_ch.ready <= (seen_count >= CALM_FROM && seen_count < CALM_TO) ||
                        $urandom_range(99) >= IDLE_PCT;
      end
    end
  end

  // Watchdog on cycles with no transaction on either channel
  always @(posedge clk) begin
    if (rst) begin
      stall_cycles <= 0;
    end else if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= WATCHDOG_LIMIT) begin
        $display("priority_lock_arbiter verification failed");
        $finish;
      end
    end
  end

  initial begin
    clk = 1'b0;
    rst = 1'b1;
    req_ch.valid = 1'b0;
    req_ch.data = '0;
    rsp_ch.ready = 1'b0;
    lock_st = lock_reset();
    plan_st = lock_reset();
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    add_req(plk_pkg::CMD_TAKE,    4'd0,  1'b0, 1'b0, 1'b0);  // free lock taken
    add_req(plk_pkg::CMD_TAKE,    4'd0,  1'b0, 1'b1, 1'b0);  // already owner
    add_req(plk_pkg::CMD_TAKE,    4'd1,  1'b0, 1'b0, 1'b0);  // busy, no wait
    add_req(plk_pkg::CMD_TAKE,    4'd3,  1'b1, 1'b1, 1'b0);  // queued, quiet
    add_req(plk_pkg::CMD_TAKE,    4'd3,  1'b1, 1'b0, 1'b0);  // queued twice
    add_req(plk_pkg::CMD_TAKE,    4'd2,  1'b1, 1'b0, 1'b0);
    add_req(plk_pkg::CMD_TAKE,    4'd7,  1'b1, 1'b1, 1'b0);  // highest valid id
    add_req(plk_pkg::CMD_TAKE,    4'd4,  1'b1, 1'b0, 1'b1);  // take from interrupt
    add_req(plk_pkg::CMD_TAKE,    4'd8,  1'b1, 1'b1, 1'b0);  // first invalid id
    add_req(plk_pkg::CMD_RELEASE, 4'd15, 1'b1, 1'b1, 1'b1);  // invalid id, all ones
    add_req(CMD_UNUSED,           4'd0,  1'b0, 1'b0, 1'b0);
    add_req(plk_pkg::CMD_CHANGE,  4'd0,  1'b0, 1'b1, 1'b0);  // owner goes quiet
    add_req(plk_pkg::CMD_CHANGE,  4'd1,  1'b0, 1'b0, 1'b0);  // change by non-owner
    add_req(plk_pkg::CMD_CHANGE,  4'd0,  1'b0, 1'b0, 1'b1);  // change from interrupt
    add_req(plk_pkg::CMD_RELEASE, 4'd1,  1'b0, 1'b0, 1'b0);  // release by non-owner
    add_req(plk_pkg::CMD_RELEASE, 4'd5,  1'b0, 1'b0, 1'b1);  // non-owner, interrupt
    add_req(plk_pkg::CMD_RELEASE, 4'd0,  1'b0, 1'b0, 1'b0);  // grant to lowest waiter
    add_req(plk_pkg::CMD_RELEASE, 4'd2,  1'b0, 1'b0, 1'b1);  // owner release from interrupt
    add_req(plk_pkg::CMD_TAKE,    4'd2,  1'b1, 1'b1, 1'b0);
    add_req(plk_pkg::CMD_RELEASE, 4'd3,  1'b0, 1'b0, 1'b0);
    add_req(plk_pkg::CMD_RELEASE, 4'd2,  1'b0, 1'b0, 1'b0);
    add_req(plk_pkg::CMD_RELEASE, 4'd7,  1'b0, 1'b0, 1'b0);  // nobody left waiting
    add_req(plk_pkg::CMD_RELEASE, 4'd7,  1'b0, 1'b0, 1'b0);  // release of a free lock
    add_req(plk_pkg::CMD_CHANGE,  4'd0,  1'b0, 1'b0, 1'b0);  // change on a free lock
    add_req(plk_pkg::CMD_TAKE,    4'd6,  1'b0, 1'b1, 1'b0);
    add_req(plk_pkg::CMD_RELEASE, 4'd6,  1'b0, 1'b0, 1'b0);
    wait_drained();

    repeat (RANDOM_ITEMS / 2) add_random_req();
    wait_drained();   // sender pause until all responses are back
    repeat (RANDOM_ITEMS - RANDOM_ITEMS / 2) add_random_req();
    wait_drained();
    repeat (4) @(posedge clk);

    if (fail_count == 0 && expected_rsps.size() == 0) begin
      $display("priority_lock_arbiter verification clean");
    end else begin
      $display("priority_lock_arbiter verification failed");
    end
    $finish;
  end

endmodule
`default_nettype wire

/* files.f */
+incdir+hw/rtl
hw/rtl/plk_pkg.sv
hw/rtl/plk_req_if.sv
hw/rtl/plk_rsp_if.sv
hw/rtl/plk_datapath.sv
hw/rtl/plk_controller.sv
hw/rtl/priority_lock_arbiter.sv
test/priority_lock_arbiter_tb.sv
